/* design/color_string_parser_assert.svh */
// Assertion macros shared by the colour string parser modules.
// Depends on nothing; included by files that assert.
`ifndef COLOR_STRING_PARSER_ASSERT_SVH
`define COLOR_STRING_PARSER_ASSERT_SVH
// Implication checked on every edge outside reset.
`define CSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* design/csp_pkg.sv */
// Package for the colour string parser: name table, widths and helpers.
// Depends on nothing.
`timescale 1ns / 1ps
package csp_pkg;
  localparam int NameCount = 148;
  localparam int MaxNameLen = 20;
  localparam int PosW = 5;
  localparam logic [PosW-1:0] PosMax = 5'd31;
  localparam logic [7:0] CharHash = 8'h23;

  typedef logic [MaxNameLen*8-1:0] name_str_t;
  typedef logic [23:0] rgb_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    rgb_t rgb_value;
    logic is_valid;
  } out_item_t;

  localparam name_str_t NAME_STR [NameCount] = '{
    "aliceblue","antiquewhite","aqua","aquamarine","azure",
    "beige","bisque","black","blanchedalmond","blue",
    "blueviolet","brown","burlywood","cadetblue","chartreuse",
    "chocolate","coral","cornflowerblue","cornsilk","crimson",
    "cyan","darkblue","darkcyan","darkgoldenrod","darkgray",
    "darkgreen","darkgrey","darkkhaki","darkmagenta",
    "darkolivegreen","darkorange","darkorchid","darkred",
    "darksalmon","darkseagreen","darkslateblue","darkslategray",
    "darkslategrey","darkturquoise","darkviolet","deeppink",
    "deepskyblue","dimgray","dimgrey","dodgerblue","firebrick",
    "floralwhite","forestgreen","fuchsia","gainsboro",
    "ghostwhite","gold","goldenrod","gray","green",
    "greenyellow","grey","honeydew","hotpink","indianred",
    "indigo","ivory","khaki","lavender","lavenderblush",
    "lawngreen","lemonchiffon","lightblue","lightcoral",
    "lightcyan","lightgoldenrodyellow","lightgray","lightgreen",
    "lightgrey","lightpink","lightsalmon","lightseagreen",
    "lightskyblue","lightslategray","lightslategrey","lightsteelblue",
    "lightyellow","lime","limegreen","linen","magenta",
    "maroon","mediumaquamarine","mediumblue","mediumorchid",
    "mediumpurple","mediumseagreen","mediumslateblue","mediumspringgreen",
    "mediumturquoise","mediumvioletred","midnightblue","mintcream",
    "mistyrose","moccasin","navajowhite","navy","oldlace",
    "olive","olivedrab","orange","orangered","orchid",
    "palegoldenrod","palegreen","paleturquoise","palevioletred",
    "papayawhip","peachpuff","peru","pink","plum",
    "powderblue","purple","rebeccapurple","red","rosybrown",
    "royalblue","saddlebrown","salmon","sandybrown","seagreen",
    "seashell","sienna","silver","skyblue","slateblue",
    "slategray","slategrey","snow","springgreen","steelblue",
    "tan","teal","thistle","tomato","turquoise",
    "violet","wheat","white","whitesmoke","yellow","yellowgreen"
  };

  localparam rgb_t NAME_RGB [NameCount] = '{
    24'hf0f8ff,24'hfaebd7,24'h00ffff,24'h7fffd4,24'hf0ffff,
    24'hf5f5dc,24'hffe4c4,24'h000000,24'hffebcd,24'h0000ff,
    24'h8a2be2,24'ha52a2a,24'hdeb887,24'h5f9ea0,24'h7fff00,
    24'hd2691e,24'hff7f50,24'h6495ed,24'hfff8dc,24'hdc143c,
    24'h00ffff,24'h00008b,24'h008b8b,24'hb8860b,24'ha9a9a9,
    24'h006400,24'ha9a9a9,24'hbdb76b,24'h8b008b,
    24'h556b2f,24'hff8c00,24'h9932cc,24'h8b0000,
    24'he9967a,24'h8fbc8f,24'h483d8b,24'h2f4f4f,
    24'h2f4f4f,24'h00ced1,24'h9400d3,24'hff1493,
    24'h00bfff,24'h696969,24'h696969,24'h1e90ff,24'hb22222,
    24'hfffaf0,24'h228b22,24'hff00ff,24'hdcdcdc,
    24'hf8f8ff,24'hffd700,24'hdaa520,24'h808080,24'h008000,
    24'hadff2f,24'h808080,24'hf0fff0,24'hff69b4,24'hcd5c5c,
    24'h4b0082,24'hfffff0,24'hf0e68c,24'he6e6fa,24'hfff0f5,
    24'h7cfc00,24'hfffacd,24'hadd8e6,24'hf08080,
    24'he0ffff,24'hfafad2,24'hd3d3d3,24'h90ee90,
    24'hd3d3d3,24'hffb6c1,24'hffa07a,24'h20b2aa,
    24'h87cefa,24'h778899,24'h778899,24'hb0c4de,
    24'hffffe0,24'h00ff00,24'h32cd32,24'hfaf0e6,24'hff00ff,
    24'h800000,24'h66cdaa,24'h0000cd,24'hba55d3,
    24'h9370db,24'h3cb371,24'h7b68ee,24'h00fa9a,
    24'h48d1cc,24'hc71585,24'h191970,24'hf5fffa,
    24'hffe4e1,24'hffe4b5,24'hffdead,24'h000080,24'hfdf5e6,
    24'h808000,24'h6b8e23,24'hffa500,24'hff4500,24'hda70d6,
    24'heee8aa,24'h98fb98,24'hafeeee,24'hdb7093,
    24'hffefd5,24'hffdab9,24'hcd853f,24'hffc0cb,24'hdda0dd,
    24'hb0e0e6,24'h800080,24'h663399,24'hff0000,24'hbc8f8f,
    24'h4169e1,24'h8b4513,24'hfa8072,24'hf4a460,24'h2e8b57,
    24'hfff5ee,24'ha0522d,24'hc0c0c0,24'h87ceeb,24'h6a5acd,
    24'h708090,24'h708090,24'hfffafa,24'h00ff7f,24'h4682b4,
    24'hd2b48c,24'h008080,24'hd8bfd8,24'hff6347,24'h40e0d0,
    24'hee82ee,24'hf5deb3,24'hffffff,24'hf5f5f5,24'hffff00,24'h9acd32
  };

  // Label length: count non-zero bytes (strings are right-aligned, zero padded on the left).
  function automatic logic [PosW-1:0] name_len(input name_str_t s);
    logic [PosW-1:0] n;
    n = '0;
    for (int k = 0; k < MaxNameLen; k++) begin
      if (s[k*8 +: 8] != 8'h00) n = n + 1'b1;
    end
    return n;
  endfunction

  // Character at position p (0 = first) of a label of length n; zero beyond the end.
  function automatic logic [7:0] name_char(input name_str_t s, input int p);
    int n;
    n = int'(name_len(s));
    if (p < n) return s[(n-1-p)*8 +: 8];
    return 8'h00;
  endfunction
endpackage

/* design/csp_stream_if.sv */
// Valid/ready channel carrying one payload type.
// Depends on csp_pkg only through the payload type supplied by the user.
`timescale 1ns / 1ps
interface csp_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/color_string_parser.sv */
// Colour string parser: a string of characters, one per request, gives one colour result.
// Accepts '#' with 3 or 6 hex digits, or a colour name matched without regard to case.
// Channels: in (char_code, is_last) and out (rgb_value, is_valid), both valid/ready.
// One character is taken per cycle while input ready is high; the result for the last
// character appears in the output register in the cycle after that character is accepted.
// The per-character work (hex digit shift, 148-entry name compare) is one combinational
// step between the parse state registers and the output register.
// A stalled result holds in the output register; the next character is still taken
// while the register is empty or drained in the same cycle, so input ready follows
// output ready whenever a result is waiting.
// Synchronous active-low reset empties the output register and returns the parse
// state to the start of a string.
`timescale 1ns / 1ps
`include "color_string_parser_assert.svh"
module color_string_parser (
  input logic clk,
  input logic rst_n,
  csp_stream_if.sink   in_ch,
  csp_stream_if.source out_ch
);
  logic [csp_pkg::PosW-1:0] pos_r;
  csp_pkg::rgb_t            acc_r;
  logic                     hash_r, hexok_r;
  logic                     out_valid_r;
  csp_pkg::out_item_t       out_data_r;

  logic [7:0] c, lc;
  logic       take, last;
  logic       hex_is, first_hash, hash_now, hexok_now;
  logic [3:0] dval;
  csp_pkg::rgb_t acc_now, short_rgb;
  logic       hit;
  csp_pkg::rgb_t hit_rgb;
  csp_pkg::out_item_t res;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign take = in_ch.valid && in_ch.ready;
  assign c    = in_ch.data.char_code;
  assign last = in_ch.data.is_last;
  assign lc   = (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;

  always_comb begin
    hex_is = 1'b1;
    dval = '0;
    if (c >= 8'h30 && c <= 8'h39) dval = 4'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) dval = 4'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) dval = 4'(c - 8'h37);
    else hex_is = 1'b0;
  end

  assign first_hash = (pos_r == '0);
  assign hash_now  = first_hash ? (c == csp_pkg::CharHash) : hash_r;
  assign hexok_now = (first_hash || hex_is) ? hexok_r : 1'b0;
  assign acc_now   = (!first_hash && hex_is) ? {acc_r[19:0], dval} : acc_r;
  assign short_rgb = {acc_now[11:8], acc_now[11:8], acc_now[7:4], acc_now[7:4],
                      acc_now[3:0], acc_now[3:0]};

  csp_name_match u_match (
    .clk(clk), .rst_n(rst_n), .step(take), .clear(last),
    .lc_char(lc), .pos(pos_r), .hit(hit), .hit_rgb(hit_rgb)
  );

  always_comb begin
    res = '0;
    if (hash_now) begin
      if (hexok_now && pos_r == 5'd6) begin
        res.rgb_value = acc_now; res.is_valid = 1'b1;
      end else if (hexok_now && pos_r == 5'd3) begin
        res.rgb_value = short_rgb; res.is_valid = 1'b1;
      end
    end else if (hit) begin
      res.rgb_value = hit_rgb; res.is_valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; acc_r <= '0; hash_r <= 1'b0; hexok_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      // Load on a last character, otherwise hold until drained.
      out_valid_r <= (take && last) || (out_valid_r && !out_ch.ready);
      if (take) begin
        if (last) begin
          pos_r <= '0; acc_r <= '0; hash_r <= 1'b0; hexok_r <= 1'b1;
          out_data_r <= res;
        end else begin
          if (pos_r != csp_pkg::PosMax) pos_r <= pos_r + 1'b1;
          acc_r <= acc_now; hash_r <= hash_now; hexok_r <= hexok_now;
        end
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  `CSP_ASSERT_NEXT(a_last_gives_result, clk, rst_n, take && last, out_valid_r)
  `CSP_ASSERT_IMP(a_invalid_is_black, clk, rst_n, out_valid_r && !out_data_r.is_valid,
    out_data_r.rgb_value == '0)
  `CSP_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid_r && !out_ch.ready,
    out_valid_r && $stable(out_data_r))
  `CSP_ASSERT_NEXT(a_restart, clk, rst_n, take && last, pos_r == '0 && hexok_r)
endmodule

/* design/csp_name_match.sv */
// Name matcher: one still-matching bit per colour name, updated per character.
// Depends on csp_pkg.
`timescale 1ns / 1ps
module csp_name_match (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic                      clear,
  input  logic [7:0]                lc_char,
  input  logic [csp_pkg::PosW-1:0]  pos,
  output logic                      hit,
  output csp_pkg::rgb_t             hit_rgb
);
  logic [csp_pkg::NameCount-1:0] mask_r, mask_nxt;

  always_comb begin
    logic [csp_pkg::NameCount-1:0] m;
    logic found;
    csp_pkg::rgb_t col;
    found = 1'b0;
    col = '0;
    for (int i = 0; i < csp_pkg::NameCount; i++) begin
      m[i] = mask_r[i] && (pos < csp_pkg::name_len(csp_pkg::NAME_STR[i])) &&
             (lc_char == csp_pkg::name_char(csp_pkg::NAME_STR[i], int'(pos)));
    end
    // First entry whose full length equals the string length wins.
    for (int i = csp_pkg::NameCount - 1; i >= 0; i--) begin
      if (m[i] && csp_pkg::name_len(csp_pkg::NAME_STR[i]) == pos + 1'b1) begin
        found = 1'b1;
        col = csp_pkg::NAME_RGB[i];
      end
    end
    mask_nxt = m;
    hit = found;
    hit_rgb = col;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && clear)) begin
      mask_r <= '1;
    end else if (step) begin
      mask_r <= mask_nxt;
    end
  end
endmodule
